// ===== sv/clook_pkg.sv =====
// shared types and constants for the c-look disk scheduler
`timescale 1ns / 1ps
`default_nettype none

package clook_pkg;

  // sizes
  localparam int MAX_REQUESTS = 32;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W        = $clog2(MAX_REQUESTS);
  localparam int CYL_W        = 16;
  localparam int SEEK_W       = 22;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  // register index, taken from paddr[2]
  localparam logic REG_HEAD = 1'b0;
  localparam logic REG_PREV = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HEAD,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic ins;        // insert the accepted request
    logic srch_clr;   // reset the split index
    logic srch_inc;   // advance the split index
    logic emit_head;  // put the head out as first result
    logic emit_next;  // put the next stored cylinder out
    logic batch_clr;  // end of batch: empty the store
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic h_stop;     // split point found
    logic cnt_zero;   // store holds no request
    logic last_one;   // one stored cylinder left to emit
  } status_t;

endpackage

`default_nettype wire

// ===== sv/clook_ctrl.sv =====
// controller state machine for the c-look disk scheduler
`timescale 1ns / 1ps
`default_nettype none

module clook_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last_request,
  input  clook_pkg::status_t status,
  output clook_pkg::cmd_t    cmd,
  output logic              busy
);
  import clook_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.ins = 1'b1;
          if (last_request) begin
            cmd.srch_clr = 1'b1;
            state_next   = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (status.h_stop) begin
          state_next = ST_HEAD;
        end else begin
          cmd.srch_inc = 1'b1;
        end
      end
      ST_HEAD: begin
        cmd.emit_head = 1'b1;
        if (status.cnt_zero) begin
          cmd.batch_clr = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_next = 1'b1;
        if (status.last_one) begin
          cmd.batch_clr = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/clook_dpath.sv =====
// datapath: sorted insertion cells, split search, service-order walk
`timescale 1ns / 1ps
`default_nettype none

module clook_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  clook_pkg::cmd_t              cmd,
  output clook_pkg::status_t           status,
  input  logic [clook_pkg::CYL_W-1:0]  request_cylinder,
  input  logic [clook_pkg::CYL_W-1:0]  head,
  input  logic [clook_pkg::CYL_W-1:0]  prev,
  output logic                         result_strobe,
  output logic [clook_pkg::CYL_W-1:0]  served_cylinder,
  output logic [clook_pkg::SEEK_W-1:0] seek_total,
  output logic                         overflow_flag,
  output logic                         last_result
);
  import clook_pkg::*;

  logic [CYL_W-1:0]  cells [MAX_REQUESTS];
  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic [CNT_W-1:0]  h;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  rem;
  logic              skip;
  logic [CYL_W-1:0]  last_cyl;
  logic [SEEK_W-1:0] acc;

  logic [MAX_REQUESTS-1:0] gt;
  logic [MAX_REQUESTS-1:0] wr;
  logic [CYL_W-1:0]        nv [MAX_REQUESTS];
  logic                    full;
  logic                    up;
  logic [CYL_W-1:0]        h_cell;
  logic                    h_go;
  logic [IDX_W-1:0]        top_idx;
  logic [CYL_W-1:0]        cur;
  logic [CYL_W-1:0]        diff;
  logic [SEEK_W:0]         sum_w;
  logic [SEEK_W-1:0]       sum_sat;

  assign full    = (count >= CNT_W'(MAX_REQUESTS));
  assign up      = (prev < head);
  assign top_idx = IDX_W'(count - CNT_W'(1));

  // insertion cells: entries above the new value move up one place
  genvar g;
  generate
    for (g = 0; g < MAX_REQUESTS; g++) begin : g_cell
      assign gt[g] = (CNT_W'(g) < count) && (cells[g] > request_cylinder);
      assign wr[g] = gt[g] || (CNT_W'(g) == count);
      if (g == 0) begin : g_first
        assign nv[g] = request_cylinder;
      end else begin : g_rest
        assign nv[g] = gt[g-1] ? cells[g-1] : request_cylinder;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.ins && !full) begin
      for (int i = 0; i < MAX_REQUESTS; i++) begin
        if (wr[i]) begin
          cells[i] <= nv[i];
        end
      end
    end
  end

  // split search: first entry past the head in sweep sense
  assign h_cell = cells[h[IDX_W-1:0]];
  assign h_go   = (h < count) && (up ? (h_cell < head) : (h_cell <= head));

  // walk step: distance from the last served cylinder
  assign cur     = cells[idx];
  assign diff    = up ? (cur - last_cyl) : (last_cyl - cur);
  assign sum_w   = {1'b0, acc} + (skip ? '0 : (SEEK_W+1)'(diff));
  assign sum_sat = sum_w[SEEK_W] ? {SEEK_W{1'b1}} : sum_w[SEEK_W-1:0];

  assign status.h_stop   = !h_go;
  assign status.cnt_zero = (count == '0);
  assign status.last_one = (rem == CNT_W'(1));

  // batch control: fill count and drop mark
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.batch_clr) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.ins) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // search index and walk registers
  always_ff @(posedge clk) begin
    if (cmd.srch_clr) begin
      h <= '0;
    end else if (cmd.srch_inc) begin
      h <= h + CNT_W'(1);
    end
    if (cmd.emit_head) begin
      rem      <= count;
      last_cyl <= head;
      acc      <= '0;
      if (up) begin
        skip <= (h == count);
        idx  <= (h == count) ? '0 : h[IDX_W-1:0];
      end else begin
        skip <= (h == '0);
        idx  <= (h == '0) ? top_idx : IDX_W'(h - CNT_W'(1));
      end
    end else if (cmd.emit_next) begin
      rem      <= rem - CNT_W'(1);
      last_cyl <= cur;
      acc      <= sum_sat;
      if (up) begin
        skip <= (idx == top_idx);
        idx  <= (idx == top_idx) ? '0 : idx + IDX_W'(1);
      end else begin
        skip <= (idx == '0);
        idx  <= (idx == '0) ? top_idx : idx - IDX_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit_head || cmd.emit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_head) begin
      served_cylinder <= head;
      seek_total      <= '0;
      overflow_flag   <= dropped;
      last_result     <= (count == '0);
    end else if (cmd.emit_next) begin
      served_cylinder <= cur;
      seek_total      <= status.last_one ? sum_sat : '0;
      overflow_flag   <= dropped;
      last_result     <= status.last_one;
    end
  end

`ifndef SYNTH
  // the store is empty again once the final beat is out
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last_result |-> (count == '0) && !dropped)
    else $error("store not cleared at end of batch");

  // seek total shows only on the final beat
  a_seek_only_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last_result |-> seek_total == '0)
    else $error("seek total on a non-final beat");

  // a request into a full store is flagged
  a_drop_flag: assert property (@(posedge clk) disable iff (rst)
    cmd.ins && full |=> dropped)
    else $error("dropped request not flagged");
`endif

endmodule

`default_nettype wire

// ===== sv/c_look_disk_scheduler_unit.sv =====
// top level of the c-look disk scheduler: apb registers, controller, datapath
//
//  channel   ports                                         beat taken when
//  request   start, busy, request_cylinder, last_request   start && !busy
//  result    result_strobe, served_cylinder, seek_total,   result_strobe high
//            overflow_flag, last_result
//  config    psel, penable, pwrite, paddr, pwdata, prdata  psel && penable && pwrite
//
// a request that is not the last of its batch is inserted while busy stays low
// the last request is inserted, then a split search runs over the sorted cells
// (h = entries before the split), then m + 1 result beats follow, with m the
// number of stored requests
// result beats come one per cycle from an output register and cannot be stalled
// synchronous reset empties the store and clears both registers to zero
`timescale 1ns / 1ps
`default_nettype none

module c_look_disk_scheduler_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [clook_pkg::CYL_W-1:0]   request_cylinder,
  input  logic                          last_request,
  output logic                          result_strobe,
  output logic [clook_pkg::CYL_W-1:0]   served_cylinder,
  output logic [clook_pkg::SEEK_W-1:0]  seek_total,
  output logic                          overflow_flag,
  output logic                          last_result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clook_pkg::APB_AW-1:0]  paddr,
  input  logic [clook_pkg::APB_DW-1:0]  pwdata,
  output logic [clook_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import clook_pkg::*;

  logic [CYL_W-1:0] head_cylinder;
  logic [CYL_W-1:0] previous_cylinder;
  cmd_t             cmd;
  status_t          status;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_cylinder     <= '0;
      previous_cylinder <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_HEAD: head_cylinder     <= pwdata[CYL_W-1:0];
        REG_PREV: previous_cylinder <= pwdata[CYL_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_sel)
      REG_HEAD: prdata = APB_DW'(head_cylinder);
      REG_PREV: prdata = APB_DW'(previous_cylinder);
      default:  prdata = '0;
    endcase
  end

  clook_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_request (last_request),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  clook_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .request_cylinder (request_cylinder),
    .head             (head_cylinder),
    .prev             (previous_cylinder),
    .result_strobe    (result_strobe),
    .served_cylinder  (served_cylinder),
    .seek_total       (seek_total),
    .overflow_flag    (overflow_flag),
    .last_result      (last_result)
  );

endmodule

`default_nettype wire
